// File: hdl/lpse_pkg.sv
// Shared types and constants for the LED pixel SPI encoder.
// Standalone; imported by led_pixel_spi_encoder_core.
package lpse_pkg;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic       last_pixel;
	} pix_t;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       last_byte;
	} spi_t;

	typedef enum logic [2:0] {
		RGN_0,
		RGN_1,
		RGN_2,
		RGN_3,
		RGN_4,
		RGN_5
	} region_t;

	localparam logic       CFG_HUE_MODE  = 1'b0;
	localparam logic       CFG_GRB_ORDER = 1'b1;

	localparam logic [3:0] SYM_ZERO      = 4'h8;
	localparam logic [3:0] SYM_ONE       = 4'hC;
	localparam logic [7:0] HUE_SPAN      = 8'd43;
	localparam logic [7:0] FULL_SCALE    = 8'd255;
	localparam logic [7:0] LATCH_VALUE   = 8'h00;
	localparam logic [3:0] LAST_PIX_IDX  = 4'd11;
	localparam logic [3:0] LAST_LATCH_IDX = 4'd14;

endpackage

// File: hdl/led_pixel_spi_encoder_core.sv
// Pixels are taken back to back until the four pipeline stages and the serialiser hold five;
// after that one pixel is taken each time the serialiser finishes one: 12 SPI bytes (15 for
// the pixel marked last), one SPI byte per cycle while spi_stall is low, with no gap between
// pixels. Stalls on the SPI side hold the serialiser and back up into the pixel input. In an
// empty block a pixel passes four register stages that do the hue conversion and channel
// ordering, then the serialiser loads and presents the pixel's first byte.
// Top level: hue conversion pipeline and SPI bit-symbol serialiser; uses lpse_pkg.
module led_pixel_spi_encoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  lpse_pkg::pix_t       pix,
	output logic                 spi_valid,
	input  logic                 spi_stall,
	output lpse_pkg::spi_t       spi
);
	import lpse_pkg::*;

	logic hue_mode_q, grb_order_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_mode_q  <= 1'b0;
			grb_order_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				CFG_HUE_MODE:  hue_mode_q  <= pwdata[0];
				CFG_GRB_ORDER: grb_order_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			CFG_HUE_MODE:  prdata[0] = hue_mode_q;
			CFG_GRB_ORDER: prdata[0] = grb_order_q;
			default: ;
		endcase
	end

	// pipeline flow control
	logic v_s1, v_s2, v_s3, v_s4, ser_v_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_ser;
	logic ser_done;
	logic [3:0] cnt_q;
	logic       ser_last_q;
	logic [23:0] word_q;

	assign ser_done = ser_v_q && !spi_stall &&
		(cnt_q == LAST_LATCH_IDX || (cnt_q == LAST_PIX_IDX && !ser_last_q));
	assign ld_ser = !ser_v_q || ser_done;
	assign ld_s4  = !v_s4 || ld_ser;
	assign ld_s3  = !v_s3 || ld_s4;
	assign ld_s2  = !v_s2 || ld_s3;
	assign ld_s1  = !v_s1 || ld_s2;
	assign pix_stall = !ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld_s1) v_s1 <= pix_valid;
			if (ld_s2) v_s2 <= v_s1;
			if (ld_s3) v_s3 <= v_s2;
			if (ld_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: hue region and scaled remainder
	region_t    rgn_n;
	logic [7:0] base_n;
	logic [7:0] rem_n;

	always_comb begin
		priority if (pix.chan_a >= 8'(5 * HUE_SPAN)) rgn_n = RGN_5;
		else if (pix.chan_a >= 8'(4 * HUE_SPAN)) rgn_n = RGN_4;
		else if (pix.chan_a >= 8'(3 * HUE_SPAN)) rgn_n = RGN_3;
		else if (pix.chan_a >= 8'(2 * HUE_SPAN)) rgn_n = RGN_2;
		else if (pix.chan_a >= HUE_SPAN) rgn_n = RGN_1;
		else rgn_n = RGN_0;
		base_n = 8'(8'(rgn_n) * HUE_SPAN);
		rem_n  = 8'((pix.chan_a - base_n) * 8'd6);
	end

	pix_t       pix_s1;
	region_t    rgn_s1;
	logic [7:0] rem_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			pix_s1 <= pix;
			rgn_s1 <= rgn_n;
			rem_s1 <= rem_n;
		end
	end

	// stage 2: saturation products
	logic [15:0] sr_n, sr2_n;
	assign sr_n  = pix_s1.chan_b * rem_s1;
	assign sr2_n = pix_s1.chan_b * (FULL_SCALE - rem_s1);

	pix_t       pix_s2;
	region_t    rgn_s2;
	logic [7:0] x1_s2, x2_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			pix_s2 <= pix_s1;
			rgn_s2 <= rgn_s1;
			x1_s2  <= sr_n[15:8];
			x2_s2  <= sr2_n[15:8];
		end
	end

	// stage 3: value products
	logic [15:0] p_n, q_n, t_n;
	assign p_n = pix_s2.chan_c * (FULL_SCALE - pix_s2.chan_b);
	assign q_n = pix_s2.chan_c * (FULL_SCALE - x1_s2);
	assign t_n = pix_s2.chan_c * (FULL_SCALE - x2_s2);

	pix_t       pix_s3;
	region_t    rgn_s3;
	logic [7:0] p_s3, q_s3, t_s3;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			pix_s3 <= pix_s2;
			rgn_s3 <= rgn_s2;
			p_s3   <= p_n[15:8];
			q_s3   <= q_n[15:8];
			t_s3   <= t_n[15:8];
		end
	end

	// stage 4: sector select and channel order
	logic [7:0] r_n, g_n, b_n, v3;
	assign v3 = pix_s3.chan_c;

	always_comb begin
		r_n = pix_s3.chan_a;
		g_n = pix_s3.chan_b;
		b_n = pix_s3.chan_c;
		if (hue_mode_q) begin
			if (pix_s3.chan_b == 8'd0) begin
				r_n = v3;
				g_n = v3;
				b_n = v3;
			end else begin
				unique case (rgn_s3)
					RGN_0: begin r_n = v3;   g_n = t_s3; b_n = p_s3; end
					RGN_1: begin r_n = q_s3; g_n = v3;   b_n = p_s3; end
					RGN_2: begin r_n = p_s3; g_n = v3;   b_n = t_s3; end
					RGN_3: begin r_n = p_s3; g_n = q_s3; b_n = v3;   end
					RGN_4: begin r_n = t_s3; g_n = p_s3; b_n = v3;   end
					default: begin r_n = v3; g_n = p_s3; b_n = q_s3; end
				endcase
			end
		end
	end

	logic [23:0] word_s4;
	logic        last_s4;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			word_s4 <= grb_order_q ? {g_n, r_n, b_n} : {r_n, g_n, b_n};
			last_s4 <= pix_s3.last_pixel;
		end
	end

	// serialiser: two colour bits per byte, then latch bytes for the pixel marked last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_v_q    <= 1'b0;
			cnt_q      <= '0;
			ser_last_q <= 1'b0;
		end else if (ld_ser) begin
			ser_v_q    <= v_s4;
			cnt_q      <= '0;
			ser_last_q <= last_s4;
		end else if (!spi_stall) begin
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_ser) begin
			word_q <= word_s4;
		end else if (!spi_stall) begin
			word_q <= {word_q[21:0], 2'b00};
		end
	end

	assign spi_valid     = ser_v_q;
	assign spi.spi_byte  = (cnt_q > LAST_PIX_IDX) ? LATCH_VALUE :
		{(word_q[23] ? SYM_ONE : SYM_ZERO), (word_q[22] ? SYM_ONE : SYM_ZERO)};
	assign spi.last_byte = (cnt_q == LAST_LATCH_IDX) ||
		(cnt_q == LAST_PIX_IDX && !ser_last_q);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_v_q |-> cnt_q <= LAST_LATCH_IDX)
		else $error("serialiser count out of range");

	a_cnt_short: assert property (@(posedge clk) disable iff (!arst_n)
		ser_v_q && !ser_last_q |-> cnt_q <= LAST_PIX_IDX)
		else $error("latch bytes on a pixel not marked last");

	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid && !spi_stall && !spi.last_byte |=> spi_valid)
		else $error("gap inside a pixel transaction");

	a_latch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		spi_valid && cnt_q > LAST_PIX_IDX |-> spi.spi_byte == LATCH_VALUE)
		else $error("latch byte not zero");

	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !ld_ser |=> v_s4 && $stable(word_s4))
		else $error("blocked stage lost its transaction");

endmodule

// File: test/led_pixel_spi_encoder_core_test.sv
// Self-checking bench for led_pixel_spi_encoder_core: pixels in, SPI symbol bytes out.
// Drives the APB register port and both valid/stall channels, predicting every byte.
// Depends on lpse_pkg and led_pixel_spi_encoder_core.
module led_pixel_spi_encoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lpse_pkg::*;

	localparam int HOLD_AFTER = 600;
	localparam int LONG_HOLD  = 300;
	localparam int ITEMS_PER_PHASE = 73;

	class spi_byte_board;
		bit hue_mode  = 1'b0;
		bit grb_order = 1'b1;
		spi_t due_bytes[$];
		int byte_errors;
		int bytes_seen;

		function void hsv_to_rgb(input int unsigned h, input int unsigned s,
				input int unsigned v, output logic [7:0] r, output logic [7:0] g,
				output logic [7:0] b);
			int unsigned region, rem, p, q, t;
			if (s == 0) begin
				r = v[7:0];
				g = v[7:0];
				b = v[7:0];
				return;
			end
			region = h / HUE_SPAN;
			rem = (h - region * HUE_SPAN) * 6;
			p = (v * (FULL_SCALE - s)) >> 8;
			q = (v * (FULL_SCALE - ((s * rem) >> 8))) >> 8;
			t = (v * (FULL_SCALE - ((s * (FULL_SCALE - rem)) >> 8))) >> 8;
			case (region_t'(region[2:0]))
				RGN_0: begin r = v[7:0]; g = t[7:0]; b = p[7:0]; end
				RGN_1: begin r = q[7:0]; g = v[7:0]; b = p[7:0]; end
				RGN_2: begin r = p[7:0]; g = v[7:0]; b = t[7:0]; end
				RGN_3: begin r = p[7:0]; g = q[7:0]; b = v[7:0]; end
				RGN_4: begin r = t[7:0]; g = p[7:0]; b = v[7:0]; end
				default: begin r = v[7:0]; g = p[7:0]; b = q[7:0]; end
			endcase
		endfunction

		function void encode_pixel(pix_t px);
			logic [7:0] red, green, blue;
			logic [7:0] order[3];
			logic [7:0] seq[15];
			logic [7:0] colour;
			int n;
			spi_t item;
			if (hue_mode)
				hsv_to_rgb(32'(px.chan_a), 32'(px.chan_b), 32'(px.chan_c),
					red, green, blue);
			else begin
				red = px.chan_a;
				green = px.chan_b;
				blue = px.chan_c;
			end
			order[0] = grb_order ? green : red;
			order[1] = grb_order ? red : green;
			order[2] = blue;
			n = 0;
			for (int c = 0; c < 3; c++) begin
				colour = order[c];
				for (int k = 0; k < 4; k++) begin
					seq[n][7:4] = colour[7 - 2 * k] ? SYM_ONE : SYM_ZERO;
					seq[n][3:0] = colour[6 - 2 * k] ? SYM_ONE : SYM_ZERO;
					n++;
				end
			end
			if (px.last_pixel) begin
				for (int k = 0; k < 3; k++) begin
					seq[n] = LATCH_VALUE;
					n++;
				end
			end
			for (int i = 0; i < n; i++) begin
				item.spi_byte = seq[i];
				item.last_byte = (i == n - 1);
				due_bytes.push_back(item);
			end
		endfunction

		function void flag(string msg);
			byte_errors++;
			if (byte_errors <= 10)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void check_byte(spi_t got);
			spi_t want;
			bytes_seen++;
			if (due_bytes.size() == 0) begin
				flag($sformatf("unexpected byte %02h last %0b", got.spi_byte, got.last_byte));
				return;
			end
			want = due_bytes.pop_front();
			if (got.spi_byte !== want.spi_byte)
				flag($sformatf("spi_byte expected %02h got %02h", want.spi_byte, got.spi_byte));
			if (got.last_byte !== want.last_byte)
				flag($sformatf("last_byte expected %0b got %0b on byte %02h",
					want.last_byte, got.last_byte, want.spi_byte));
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        pix_valid;
	logic        pix_stall;
	pix_t        pix;
	logic        spi_valid;
	logic        spi_stall;
	spi_t        spi;

	spi_byte_board board = new;
	bit burst;

	led_pixel_spi_encoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix(pix),
		.spi_valid(spi_valid),
		.spi_stall(spi_stall),
		.spi(spi)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	function automatic pix_t make_pixel(logic [7:0] a, logic [7:0] b, logic [7:0] c,
			logic last);
		pix_t p;
		p.chan_a = a;
		p.chan_b = b;
		p.chan_c = c;
		p.last_pixel = last;
		return p;
	endfunction

	function automatic pix_t random_pixel(bit hsv);
		pix_t p;
		p.chan_a = 8'($urandom_range(0, 255));
		p.chan_b = 8'($urandom_range(0, 255));
		p.chan_c = 8'($urandom_range(0, 255));
		p.last_pixel = ($urandom_range(0, 7) == 0);
		if (hsv) begin
			case ($urandom_range(0, 7))
				0: p.chan_b = 8'd0;
				1: p.chan_a = 8'(HUE_SPAN * $urandom_range(1, 5) - $urandom_range(0, 1));
				2: p.chan_a = 8'($urandom_range(215, 255));
				3: p.chan_b = FULL_SCALE;
				4: p.chan_c = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
				default: ;
			endcase
		end else if ($urandom_range(0, 5) == 0) begin
			p.chan_a = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
			p.chan_c = $urandom_range(0, 1) ? FULL_SCALE : 8'd0;
		end
		return p;
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input bit hue, input bit grb);
		apb_write({CFG_HUE_MODE, 2'b00}, {31'd0, hue});
		apb_write({CFG_GRB_ORDER, 2'b00}, {31'd0, grb});
		board.hue_mode = hue;
		board.grb_order = grb;
	endtask

	task automatic offer(input pix_t p, input bit final_one);
		int gap;
		pix <= p;
		pix_valid <= 1'b1;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
		board.encode_pixel(p);
		gap = burst ? 0 : pick_gap();
		if (final_one || gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_phase(input bit hue, input bit grb);
		set_mode(hue, grb);
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			if (i % 20 == 0)
				burst = ($urandom_range(0, 3) == 0);
			offer(random_pixel(hue), i == ITEMS_PER_PHASE - 1);
		end
		burst = 1'b0;
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (arst_n && spi_valid && !spi_stall)
			board.check_byte(spi);
	end

	initial begin
		bit held;
		int n;
		held = 1'b0;
		spi_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && board.bytes_seen >= HOLD_AFTER && pix_valid) begin
				held = 1'b1;
				spi_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				spi_stall <= 1'b0;
				repeat ($urandom_range(1, 30)) @(posedge clk);
				n = pick_gap();
				if (n > 0) begin
					spi_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix_valid <= 1'b0;
		pix <= '0;
		burst = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		offer(make_pixel(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
		offer(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
		offer(make_pixel(8'hAA, 8'h55, 8'h0F, 1'b1), 1'b0);
		offer(make_pixel(8'h80, 8'h01, 8'hFE, 1'b0), 1'b1);
		wait_idle();

		set_mode(1'b1, 1'b1);
		offer(make_pixel(8'd77, 8'd0, 8'h9C, 1'b0), 1'b0);
		offer(make_pixel(8'd200, 8'd0, 8'hFF, 1'b1), 1'b0);
		offer(make_pixel(8'd0, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd42, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd43, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd86, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd129, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd172, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd214, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd215, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd255, 8'd255, 8'd255, 1'b0), 1'b0);
		offer(make_pixel(8'd100, 8'd128, 8'd200, 1'b0), 1'b0);
		offer(make_pixel(8'd255, 8'd1, 8'd1, 1'b1), 1'b0);
		offer(make_pixel(8'd30, 8'd255, 8'd0, 1'b0), 1'b1);
		wait_idle();

		random_phase(1'b0, 1'b0);
		random_phase(1'b1, 1'b0);
		random_phase(1'b1, 1'b1);
		random_phase(1'b0, 1'b1);

		repeat (20) @(posedge clk);
		if (board.byte_errors == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/lpse_pkg.sv
hdl/led_pixel_spi_encoder_core.sv
test/led_pixel_spi_encoder_core_test.sv
